/* design/card_machine_executor_macros.svh */
// Assertion macros of the card machine executor.
`ifndef CARD_MACHINE_EXECUTOR_MACROS_SVH
`define CARD_MACHINE_EXECUTOR_MACROS_SVH
`ifndef ASSERT_OFF
// Immediate implication, checked at every clock edge outside reset.
`define CME_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Antecedent in one cycle, consequent in the next.
`define CME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CME_ASSERT(lbl, prop, msg)
`define CME_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/cme_pkg.sv */
// Types, codes and helper functions of the card machine executor.
package cme_pkg;

    localparam int ADDR_W = 7;
    localparam logic [31:0] SPACES = 32'h2020_2020;
    localparam logic [31:0] END_MARK = 32'h2445_4E44;

    // Request kinds.
    localparam logic [2:0] REQ_CLEAR = 3'd0;
    localparam logic [2:0] REQ_LOAD  = 3'd1;
    localparam logic [2:0] REQ_START = 3'd2;
    localparam logic [2:0] REQ_STEP  = 3'd3;
    localparam logic [2:0] REQ_CARD  = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_AWAIT   = 3'd1;
    localparam logic [2:0] ST_PRINT   = 3'd2;
    localparam logic [2:0] ST_HALT    = 3'd3;
    localparam logic [2:0] ST_BADOP   = 3'd4;
    localparam logic [2:0] ST_NODATA  = 3'd5;
    localparam logic [2:0] ST_ADDR    = 3'd6;
    localparam logic [2:0] ST_IGNORED = 3'd7;

    // Run modes.
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_WAIT = 2'd2;

    // Opcode characters.
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;

    // One access to the main memory.
    typedef struct packed {
        logic              clr;
        logic              re;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       wdata;
    } t_mem_req;

    // Decoded two-digit operand.
    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] val;
    } t_opnd;

    // Operand from the third and fourth characters; ok only for two digits.
    function automatic t_opnd fn_operand(input logic [31:0] ir);
        t_opnd      res;
        logic [7:0] d2;
        logic [7:0] d3;
        d2 = ir[15:8];
        d3 = ir[7:0];
        res.ok  = (d2 >= CH_0) && (d2 <= CH_9) && (d3 >= CH_0) && (d3 <= CH_9);
        res.val = ADDR_W'(ADDR_W'(d2[3:0]) * ADDR_W'(10) + ADDR_W'(d3[3:0]));
        return res;
    endfunction

endpackage

/* design/card_machine_executor.sv */
// Top level of the card machine executor: request sequencer and result register.
//
//  Channel   Dir  tdata (lowest bit first)                                tuser     tlast
//  s_axis    in   addr 7, word 32, card_chars_0..4 64 each, card_len 6    req_type  -
//  m_axis    out  out_word 32, pc 7, flag 1                               status    last
//
// Every request goes through one memory port. Clear, load, start and every ignored or
// rejected request pass from S_EXEC to S_EMIT; a fetched step also passes S_DEC (and
// S_OPRD for LR and CR), a PD step sends its CARD_WORDS printed words from S_PEMIT, and
// an accepted data card writes its whole words in S_CARD and merges a partly filled
// word in S_CMRG unless it lies past the end. Reset and clear invalidate all memory
// valid bits together, so there is no clearing pass. A stalled result channel holds the
// sequencer in place; a new request is taken once the last result is registered.
`include "card_machine_executor_macros.svh"

module card_machine_executor import cme_pkg::*; #(
    parameter int MEM_WORDS  = 100,
    parameter int CARD_WORDS = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // addr, word, card_chars_0, card_chars_1, card_chars_2, card_chars_3,
    // card_chars_4, card_len, zero fill
    input  logic [367:0] i_s_axis_tdata,
    // req_type
    input  logic [2:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_word, pc, flag
    output logic [39:0]  o_m_axis_tdata,
    // status
    output logic [2:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast
);

    localparam int CARD_CHARS = CARD_WORDS * 4;
    localparam int CW = $clog2(CARD_WORDS + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_OPRD  = 4'd3;
    localparam logic [3:0] S_PEMIT = 4'd4;
    localparam logic [3:0] S_CARD  = 4'd5;
    localparam logic [3:0] S_CMRG  = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;

    // Control state.
    logic [3:0]        r_state, n_state;
    logic [1:0]        r_mode, n_mode;
    logic [ADDR_W-1:0] r_pc, n_pc;
    logic              r_flag, n_flag;
    logic [31:0]       r_ir, n_ir;
    logic [31:0]       r_gen, n_gen;
    logic              r_ov, n_ov;

    // Captured request and work registers.
    logic [2:0]        r_req;
    logic [ADDR_W-1:0] r_addr;
    logic [31:0]       r_word;
    logic [319:0]      r_card, n_card;
    logic [5:0]        r_len;
    logic [2:0]        r_res, n_res;
    logic [ADDR_W-1:0] r_pidx, n_pidx;
    logic [CW-1:0]     r_pcnt, n_pcnt;
    logic              r_pspace, n_pspace;
    logic [ADDR_W-1:0] r_cidx, n_cidx;
    logic [5:0]        r_rem, n_rem;

    // Result register.
    logic [2:0]        r_ostat, n_ostat;
    logic [31:0]       r_oword, n_oword;
    logic              r_olast, n_olast;
    logic [ADDR_W-1:0] r_opc, n_opc;
    logic              r_oflag, n_oflag;

    logic              w_accept;
    logic              w_ofree;
    t_mem_req          w_mreq;
    logic [31:0]       w_rdata;
    t_opnd             w_opnd_ir;
    t_opnd             w_opnd_rd;
    logic [7:0]        w_op0;
    logic [7:0]        w_op1;
    logic              w_opvalid;
    logic [31:0]       w_mask;

    cme_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_rdata (w_rdata)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ofree         = !r_ov || i_m_axis_tready;

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {r_oflag, r_opc, r_oword};
    assign o_m_axis_tuser  = r_ostat;
    assign o_m_axis_tlast  = r_olast;

    // Instruction decode from the word just fetched.
    assign w_op0     = w_rdata[31:24];
    assign w_op1     = w_rdata[23:16];
    assign w_opnd_rd = fn_operand(w_rdata);
    assign w_opnd_ir = fn_operand(r_ir);
    assign w_opvalid = ((w_op0 == CH_G) && (w_op1 == CH_D)) ||
                       ((w_op0 == CH_P) && (w_op1 == CH_D)) ||
                       ((w_op0 == CH_L) && (w_op1 == CH_R)) ||
                       ((w_op0 == CH_S) && (w_op1 == CH_R)) ||
                       ((w_op0 == CH_C) && (w_op1 == CH_R)) ||
                       ((w_op0 == CH_B) && (w_op1 == CH_T));

    // Byte mask for a partly filled card word: the leading characters are new.
    always_comb begin
        case (r_rem[1:0])
            2'd1:    w_mask = 32'hFF00_0000;
            2'd2:    w_mask = 32'hFFFF_0000;
            2'd3:    w_mask = 32'hFFFF_FF00;
            default: w_mask = 32'hFFFF_FFFF;
        endcase
    end

    // Sequencer next state and memory access.
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_pc     = r_pc;
        n_flag   = r_flag;
        n_ir     = r_ir;
        n_gen    = r_gen;
        n_card   = r_card;
        n_res    = r_res;
        n_pidx   = r_pidx;
        n_pcnt   = r_pcnt;
        n_pspace = r_pspace;
        n_cidx   = r_cidx;
        n_rem    = r_rem;
        n_ov     = r_ov && !i_m_axis_tready;
        n_ostat  = r_ostat;
        n_oword  = r_oword;
        n_olast  = r_olast;
        n_opc    = r_opc;
        n_oflag  = r_oflag;
        w_mreq   = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_EMIT;
                n_res   = ST_DONE;
                case (r_req)
                    REQ_CLEAR: begin
                        w_mreq.clr = 1'b1;
                        n_ir       = SPACES;
                        n_gen      = SPACES;
                        n_pc       = '0;
                        n_flag     = 1'b0;
                        n_mode     = MODE_IDLE;
                    end
                    REQ_LOAD: begin
                        if (r_addr < ADDR_W'(MEM_WORDS)) begin
                            w_mreq.we    = 1'b1;
                            w_mreq.addr  = r_addr;
                            w_mreq.wdata = r_word;
                        end else begin
                            n_res = ST_IGNORED;
                        end
                    end
                    REQ_START: begin
                        n_pc   = '0;
                        n_mode = MODE_RUN;
                    end
                    REQ_STEP: begin
                        if (r_mode != MODE_RUN) begin
                            n_res = ST_IGNORED;
                        end else if (r_pc >= ADDR_W'(MEM_WORDS)) begin
                            n_mode = MODE_IDLE;
                            n_res  = ST_ADDR;
                        end else begin
                            w_mreq.re   = 1'b1;
                            w_mreq.addr = r_pc;
                            n_state     = S_DEC;
                        end
                    end
                    REQ_CARD: begin
                        if (r_mode != MODE_WAIT) begin
                            n_res = ST_IGNORED;
                        end else if ((r_len >= 6'd4) && (r_card[319:288] == END_MARK)) begin
                            n_mode = MODE_IDLE;
                            n_res  = ST_NODATA;
                        end else if (!w_opnd_ir.ok || (w_opnd_ir.val >= ADDR_W'(MEM_WORDS))) begin
                            n_mode = MODE_IDLE;
                            n_res  = ST_ADDR;
                        end else begin
                            n_cidx  = w_opnd_ir.val;
                            n_rem   = (r_len > 6'(CARD_CHARS)) ? 6'(CARD_CHARS) : r_len;
                            n_state = S_CARD;
                        end
                    end
                    default: begin
                        n_res = ST_IGNORED;
                    end
                endcase
            end

            // Fetched word is on the read port: latch it and dispatch.
            S_DEC: begin
                n_ir    = w_rdata;
                n_pc    = ADDR_W'(r_pc + ADDR_W'(1));
                n_state = S_EMIT;
                n_res   = ST_DONE;
                if (w_op0 == CH_H) begin
                    n_mode = MODE_IDLE;
                    n_res  = ST_HALT;
                end else if (!w_opvalid) begin
                    n_mode = MODE_IDLE;
                    n_res  = ST_BADOP;
                end else if (!w_opnd_rd.ok || (w_opnd_rd.val >= ADDR_W'(MEM_WORDS))) begin
                    n_mode = MODE_IDLE;
                    n_res  = ST_ADDR;
                end else begin
                    case (w_op0)
                        CH_G: begin
                            n_mode = MODE_WAIT;
                            n_res  = ST_AWAIT;
                        end
                        CH_P: begin
                            w_mreq.re   = 1'b1;
                            w_mreq.addr = w_opnd_rd.val;
                            n_pidx      = w_opnd_rd.val;
                            n_pcnt      = '0;
                            n_pspace    = 1'b0;
                            n_state     = S_PEMIT;
                        end
                        CH_L, CH_C: begin
                            w_mreq.re   = 1'b1;
                            w_mreq.addr = w_opnd_rd.val;
                            n_state     = S_OPRD;
                        end
                        CH_S: begin
                            w_mreq.we    = 1'b1;
                            w_mreq.addr  = w_opnd_rd.val;
                            w_mreq.wdata = r_gen;
                        end
                        default: begin
                            if (r_flag) begin
                                n_pc = w_opnd_rd.val;
                            end
                        end
                    endcase
                end
            end

            // Operand word of LR or CR is on the read port.
            S_OPRD: begin
                n_state = S_EMIT;
                n_res   = ST_DONE;
                if (r_ir[31:24] == CH_L) begin
                    n_gen = w_rdata;
                end else begin
                    n_flag = (r_gen == w_rdata);
                end
            end

            // One printed word per transaction, next read issued alongside.
            S_PEMIT: begin
                if (w_ofree) begin
                    n_ov    = 1'b1;
                    n_ostat = ST_PRINT;
                    n_oword = r_pspace ? SPACES : w_rdata;
                    n_olast = (r_pcnt == CW'(CARD_WORDS - 1));
                    n_opc   = r_pc;
                    n_oflag = r_flag;
                    if (r_pcnt == CW'(CARD_WORDS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pidx = ADDR_W'(r_pidx + ADDR_W'(1));
                        n_pcnt = CW'(r_pcnt + CW'(1));
                        if (ADDR_W'(r_pidx + ADDR_W'(1)) < ADDR_W'(MEM_WORDS)) begin
                            w_mreq.re   = 1'b1;
                            w_mreq.addr = ADDR_W'(r_pidx + ADDR_W'(1));
                            n_pspace    = 1'b0;
                        end else begin
                            n_pspace = 1'b1;
                        end
                    end
                end
            end

            // Card words: whole words are written directly, a partial one merged.
            S_CARD: begin
                if (r_rem == 6'd0) begin
                    n_mode  = MODE_RUN;
                    n_res   = ST_DONE;
                    n_state = S_EMIT;
                end else if (r_rem < 6'd4) begin
                    if (r_cidx < ADDR_W'(MEM_WORDS)) begin
                        w_mreq.re   = 1'b1;
                        w_mreq.addr = r_cidx;
                        n_state     = S_CMRG;
                    end else begin
                        n_rem = 6'd0;
                    end
                end else begin
                    if (r_cidx < ADDR_W'(MEM_WORDS)) begin
                        w_mreq.we    = 1'b1;
                        w_mreq.addr  = r_cidx;
                        w_mreq.wdata = r_card[319:288];
                    end
                    n_card = {r_card[287:0], 32'h0};
                    n_cidx = ADDR_W'(r_cidx + ADDR_W'(1));
                    n_rem  = 6'(r_rem - 6'd4);
                end
            end

            S_CMRG: begin
                w_mreq.we    = 1'b1;
                w_mreq.addr  = r_cidx;
                w_mreq.wdata = (r_card[319:288] & w_mask) | (w_rdata & ~w_mask);
                n_rem        = 6'd0;
                n_state      = S_CARD;
            end

            // Single result of the request.
            S_EMIT: begin
                if (w_ofree) begin
                    n_ov    = 1'b1;
                    n_ostat = r_res;
                    n_oword = '0;
                    n_olast = 1'b1;
                    n_opc   = r_pc;
                    n_oflag = r_flag;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_IDLE;
            r_pc    <= '0;
            r_flag  <= 1'b0;
            r_ir    <= SPACES;
            r_gen   <= SPACES;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_pc    <= n_pc;
            r_flag  <= n_flag;
            r_ir    <= n_ir;
            r_gen   <= n_gen;
            r_ov    <= n_ov;
        end
    end

    // Captured request, work and result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_s_axis_tuser;
            r_addr <= i_s_axis_tdata[6:0];
            r_word <= i_s_axis_tdata[38:7];
            r_card <= {i_s_axis_tdata[102:39], i_s_axis_tdata[166:103],
                       i_s_axis_tdata[230:167], i_s_axis_tdata[294:231],
                       i_s_axis_tdata[358:295]};
            r_len  <= i_s_axis_tdata[364:359];
        end else begin
            r_card <= n_card;
        end
        r_res    <= n_res;
        r_pidx   <= n_pidx;
        r_pcnt   <= n_pcnt;
        r_pspace <= n_pspace;
        r_cidx   <= n_cidx;
        r_rem    <= n_rem;
        r_ostat  <= n_ostat;
        r_oword  <= n_oword;
        r_olast  <= n_olast;
        r_opc    <= n_opc;
        r_oflag  <= n_oflag;
    end

    // Checks on the sequencer.
    `CME_ASSERT_NEXT(a_accept_busy, w_accept, r_state != S_IDLE, "request not taken up")
    `CME_ASSERT(a_mem_range, (w_mreq.re || w_mreq.we) |-> w_mreq.addr < ADDR_W'(MEM_WORDS), "bad address")
    `CME_ASSERT(a_mem_port, !(w_mreq.re && w_mreq.we), "read and write together")
    `CME_ASSERT_NEXT(a_out_hold, r_ov && !i_m_axis_tready, r_ov && $stable(o_m_axis_tdata), "result lost")

endmodule

/* design/cme_mem.sv */
// Main memory: single-port word store with per-entry valid bits.
module cme_mem import cme_pkg::*; #(
    parameter int MEM_WORDS = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mem_req    i_req,
    output logic [31:0] o_rdata
);

    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    logic [31:0]          r_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] r_valid;
    logic [31:0]          r_rdata;
    logic [AW-1:0]        w_idx;

    assign w_idx   = i_req.addr[AW-1:0];
    assign o_rdata = r_rdata;

    // Valid bits: an entry never written since the last clear reads as spaces.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.clr) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[w_idx] <= 1'b1;
        end
    end

    // Word array write port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[w_idx] <= i_req.wdata;
        end
    end

    // Registered read; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_valid[w_idx] ? r_mem[w_idx] : SPACES;
        end
    end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench of the card machine executor with a transaction scoreboard.
`timescale 1ns / 1ps

module tb_top import cme_pkg::*;;

    localparam int CLK_PERIOD     = 10;
    localparam int MEM_WORDS      = 100;
    localparam int CARD_WORDS     = 10;
    localparam int RANDOM_ITEMS   = 280;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    // Request code that the block does not know.
    localparam logic [2:0] REQ_UNKNOWN = 3'd7;

    // Input tdata, lowest field in the lowest bits.
    typedef struct packed {
        logic [2:0]       fill;
        logic [5:0]       card_len;
        logic [4:0][63:0] chars;
        logic [31:0]      word;
        logic [6:0]       addr;
    } t_payload;

    typedef struct packed {
        logic [2:0] kind;
        t_payload   payload;
    } t_request;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_word;
        logic        last;
        logic [6:0]  pc;
        logic        flag;
    } t_result;

    // Shadow copy of the machine that predicts every result transaction.
    class machine_scoreboard;
        logic [31:0] memory_words [MEM_WORDS];
        logic [31:0] instr_word;
        logic [31:0] general_reg;
        logic [6:0]  counter;
        logic        cmp_flag;
        logic [1:0]  mode;
        t_result     pending_results [$];
        int          error_count;

        function new();
            clear_job();
            error_count = 0;
        endfunction

        function void clear_job();
            foreach (memory_words[i]) memory_words[i] = SPACES;
            instr_word  = SPACES;
            general_reg = SPACES;
            counter     = '0;
            cmp_flag    = 1'b0;
            mode        = MODE_IDLE;
        endfunction

        function void queue_result(logic [2:0] status, logic [31:0] out_word, logic last);
            t_result res;
            res.status   = status;
            res.out_word = out_word;
            res.last     = last;
            res.pc       = counter;
            res.flag     = cmp_flag;
            pending_results.push_back(res);
        endfunction

        // Two ASCII digits in the low characters; valid only inside the memory.
        function bit decode_operand(input logic [31:0] w, output int target);
            logic [7:0] hi;
            logic [7:0] lo;
            hi = w[15:8];
            lo = w[7:0];
            target = 0;
            if (hi < CH_0 || hi > CH_9 || lo < CH_0 || lo > CH_9) return 1'b0;
            target = int'(hi - CH_0) * 10 + int'(lo - CH_0);
            return target < MEM_WORDS;
        endfunction

        function logic [7:0] card_byte(t_payload p, int pos);
            return p.chars[pos / 8][(7 - pos % 8) * 8 +: 8];
        endfunction

        function void run_step();
            logic [7:0] op0;
            logic [7:0] op1;
            bit         known_op;
            int         target;
            if (mode != MODE_RUN) begin
                queue_result(ST_IGNORED, '0, 1'b1);
                return;
            end
            if (counter >= MEM_WORDS) begin
                mode = MODE_IDLE;
                queue_result(ST_ADDR, '0, 1'b1);
                return;
            end
            instr_word = memory_words[counter];
            counter    = counter + 7'd1;
            op0 = instr_word[31:24];
            op1 = instr_word[23:16];
            // Halt looks at the first character only.
            if (op0 == CH_H) begin
                mode = MODE_IDLE;
                queue_result(ST_HALT, '0, 1'b1);
                return;
            end
            known_op = (op0 == CH_G && op1 == CH_D) || (op0 == CH_P && op1 == CH_D) ||
                       (op0 == CH_L && op1 == CH_R) || (op0 == CH_S && op1 == CH_R) ||
                       (op0 == CH_C && op1 == CH_R) || (op0 == CH_B && op1 == CH_T);
            if (!known_op) begin
                mode = MODE_IDLE;
                queue_result(ST_BADOP, '0, 1'b1);
                return;
            end
            if (!decode_operand(instr_word, target)) begin
                mode = MODE_IDLE;
                queue_result(ST_ADDR, '0, 1'b1);
                return;
            end
            case (op0)
                CH_G: begin
                    mode = MODE_WAIT;
                    queue_result(ST_AWAIT, '0, 1'b1);
                    return;
                end
                CH_P: begin
                    // Words beyond the memory print as blanks.
                    for (int i = 0; i < CARD_WORDS; i++) begin
                        queue_result(ST_PRINT,
                                     (target + i < MEM_WORDS) ? memory_words[target + i] : SPACES,
                                     i == CARD_WORDS - 1);
                    end
                    return;
                end
                CH_L: general_reg = memory_words[target];
                CH_S: memory_words[target] = general_reg;
                CH_C: cmp_flag = (general_reg == memory_words[target]);
                default: if (cmp_flag) counter = 7'(target);
            endcase
            queue_result(ST_DONE, '0, 1'b1);
        endfunction

        function void take_card(t_payload p);
            int len;
            int target;
            int idx;
            if (mode != MODE_WAIT) begin
                queue_result(ST_IGNORED, '0, 1'b1);
                return;
            end
            len = p.card_len;
            if (len > CARD_WORDS * 4) len = CARD_WORDS * 4;
            if (len >= 4 && p.chars[0][63:32] == END_MARK) begin
                mode = MODE_IDLE;
                queue_result(ST_NODATA, '0, 1'b1);
                return;
            end
            if (!decode_operand(instr_word, target)) begin
                mode = MODE_IDLE;
                queue_result(ST_ADDR, '0, 1'b1);
                return;
            end
            // Characters land one by one; the rest of a partly filled word stays.
            for (int pos = 0; pos < len; pos++) begin
                idx = target + pos / 4;
                if (idx < MEM_WORDS)
                    memory_words[idx][(3 - pos % 4) * 8 +: 8] = card_byte(p, pos);
            end
            mode = MODE_RUN;
            queue_result(ST_DONE, '0, 1'b1);
        endfunction

        // Returns 1 when the request did more than get ignored.
        function bit note_request(t_request r);
            int first;
            first = pending_results.size();
            case (r.kind)
                REQ_CLEAR: begin
                    clear_job();
                    queue_result(ST_DONE, '0, 1'b1);
                end
                REQ_LOAD: begin
                    if (r.payload.addr < MEM_WORDS) begin
                        memory_words[r.payload.addr] = r.payload.word;
                        queue_result(ST_DONE, '0, 1'b1);
                    end else begin
                        queue_result(ST_IGNORED, '0, 1'b1);
                    end
                end
                REQ_START: begin
                    counter = '0;
                    mode    = MODE_RUN;
                    queue_result(ST_DONE, '0, 1'b1);
                end
                REQ_STEP: run_step();
                REQ_CARD: take_card(r.payload);
                default: queue_result(ST_IGNORED, '0, 1'b1);
            endcase
            return pending_results[first].status != ST_IGNORED;
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            error_count++;
        endfunction

        function void check_result(logic [2:0] status, logic [39:0] data, logic last);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending, expected none, actual status %0d data %h",
                         $time, status, data);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            if (want.status !== status)        report("status", want.status, status);
            if (want.out_word !== data[31:0])  report("out_word", want.out_word, data[31:0]);
            if (want.last !== last)            report("last", want.last, last);
            if (want.pc !== data[38:32])       report("pc", want.pc, data[38:32]);
            if (want.flag !== data[39])        report("flag", want.flag, data[39]);
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [367:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    machine_scoreboard board;
    int  work_items = 0;
    bit  calm_sender = 1'b0;
    bit  calm_receiver = 1'b0;
    bit  hold_request = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    card_machine_executor DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser),
        .o_m_axis_tlast  (m_axis_tlast)
    );

    // Idle length: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 0;
        if (r < 7) return $urandom_range(1, 3);
        if (r < 9) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] make_instr(logic [7:0] c0, logic [7:0] c1, int target);
        return {c0, c1, 8'(CH_0 + target / 10), 8'(CH_0 + target % 10)};
    endfunction

    // Mostly valid instructions aimed near the program, with some malformed ones.
    function automatic logic [31:0] rand_instr(int span);
        logic [31:0] w;
        int          target;
        if ($urandom_range(0, 3) == 0) target = $urandom_range(0, MEM_WORDS - 1);
        else target = $urandom_range(0, span);
        case ($urandom_range(0, 19))
            0, 1, 2:    w = make_instr(CH_G, CH_D, target);
            3, 4, 5:    w = make_instr(CH_P, CH_D, target);
            6, 7, 8:    w = make_instr(CH_L, CH_R, target);
            9, 10, 11:  w = make_instr(CH_S, CH_R, target);
            12, 13:     w = make_instr(CH_C, CH_R, target);
            14, 15, 16: w = make_instr(CH_B, CH_T, target);
            17:         w = {CH_H, 24'($urandom)};
            18:         w = make_instr(8'($urandom), 8'($urandom), target);
            default:    w = $urandom;
        endcase
        if ($urandom_range(0, 9) == 0) w[15:0] = 16'($urandom);
        return w;
    endfunction

    function automatic t_request plain_req(logic [2:0] kind);
        t_request r;
        r.kind    = kind;
        r.payload = '0;
        return r;
    endfunction

    function automatic t_request load_req(int addr, logic [31:0] word);
        t_request r;
        r = plain_req(REQ_LOAD);
        r.payload.addr = 7'(addr);
        r.payload.word = word;
        return r;
    endfunction

    function automatic t_request card_req(int len, bit end_mark);
        t_request r;
        r = plain_req(REQ_CARD);
        for (int k = 0; k < 5; k++) r.payload.chars[k] = {$urandom, $urandom};
        if (end_mark) r.payload.chars[0][63:32] = END_MARK;
        r.payload.card_len = 6'(len);
        return r;
    endfunction

    function automatic t_request noise_req();
        t_request r;
        r = card_req($urandom_range(0, 63), 1'b0);
        r.kind         = 3'($urandom_range(0, 7));
        r.payload.addr = 7'($urandom);
        r.payload.word = $urandom;
        return r;
    endfunction

    // Offer one request transaction and wait until the block takes it.
    task automatic send_item(input t_request r);
        int gap;
        gap = calm_sender ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = r.kind;
        s_axis_tdata  = r.payload;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (board.note_request(r)) work_items++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (board.pending_results.size() != 0) @(negedge clk);
    endtask

    // Result side: random back-pressure plus one long hold-off on request.
    initial begin
        int hold;
        int cycles;
        hold   = 0;
        cycles = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_request = 1'b0;
            end else if (hold > 0) begin
                m_axis_tready = 1'b0;
                hold--;
            end else begin
                m_axis_tready = 1'b1;
                if (!calm_receiver && $urandom_range(0, 5) == 0) hold = pick_gap();
            end
            cycles++;
            if (cycles % 200 == 0) calm_receiver = ($urandom_range(0, 3) == 0);
        end
    end

    // Every accepted result transaction is checked against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    // Watchdog: too long without any transaction on either side ends the run.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    // Stimulus: directed program first, then random jobs.
    initial begin
        int  prog_len;
        bit  hold_issued;
        hold_issued = 1'b0;
        board = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Requests that find nothing to do, and a load past the memory.
        send_item(plain_req(REQ_CLEAR));
        send_item(plain_req(REQ_STEP));
        send_item(card_req(4, 1'b1));
        send_item(plain_req(REQ_UNKNOWN));
        send_item(load_req(127, 32'hFFFF_FFFF));

        // Program that reads a long card, prints past the end, branches to the
        // top of memory, reads a short card partly beyond it and runs off the end.
        send_item(load_req(0, make_instr(CH_G, CH_D, 20)));
        send_item(load_req(1, make_instr(CH_P, CH_D, 95)));
        send_item(load_req(2, make_instr(CH_C, CH_R, 50)));
        send_item(load_req(3, make_instr(CH_B, CH_T, 97)));
        send_item(load_req(97, make_instr(CH_S, CH_R, 60)));
        send_item(load_req(98, make_instr(CH_L, CH_R, 20)));
        send_item(load_req(99, make_instr(CH_G, CH_D, 98)));
        send_item(plain_req(REQ_START));
        send_item(plain_req(REQ_STEP));
        send_item(card_req(63, 1'b0));
        repeat (6) send_item(plain_req(REQ_STEP));
        send_item(card_req(14, 1'b0));
        send_item(plain_req(REQ_STEP));

        // Halt with an arbitrary operand.
        send_item(load_req(0, {CH_H, 24'($urandom)}));
        send_item(plain_req(REQ_START));
        send_item(plain_req(REQ_STEP));
        wait_drained();

        work_items = 0;
        while (work_items < RANDOM_ITEMS) begin
            calm_sender = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0) wait_drained();
            if (!hold_issued && work_items >= 60) begin
                hold_request = 1'b1;
                hold_issued  = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) send_item(plain_req(REQ_CLEAR));
            prog_len = $urandom_range(2, 10);
            for (int k = 0; k < prog_len; k++) send_item(load_req(k, rand_instr(prog_len)));
            if ($urandom_range(0, 2) == 0) begin
                for (int k = MEM_WORDS - 3; k < MEM_WORDS; k++)
                    send_item(load_req(k, rand_instr(MEM_WORDS - 1)));
            end
            if ($urandom_range(0, 7) == 0)
                send_item(load_req($urandom_range(MEM_WORDS, 127), $urandom));
            if ($urandom_range(0, 9) == 0) send_item(noise_req());
            send_item(plain_req(REQ_START));

            // Run the job, feeding a card whenever the machine waits for one.
            for (int k = 0; k < 24 && board.mode != MODE_IDLE; k++) begin
                if ($urandom_range(0, 14) == 0) begin
                    send_item(noise_req());
                end else if (board.mode == MODE_WAIT) begin
                    case ($urandom_range(0, 9))
                        0:       send_item(card_req($urandom_range(41, 63), 1'b0));
                        1:       send_item(card_req($urandom_range(0, 63), 1'b1));
                        default: send_item(card_req($urandom_range(0, 40), 1'b0));
                    endcase
                end else begin
                    send_item(plain_req(REQ_STEP));
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.error_count == 0 && board.pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
